// ===== rtl/swg_pkg.sv =====
`timescale 1ns / 1ps

package swg_pkg;

	// field and register widths
	localparam int DATA_W   = 32;
	localparam int AMP_W    = 31;
	localparam int DUTY_W   = 17;
	localparam int WAVE_W   = 2;
	localparam int FRAC_W   = 16;

	// quarter-wave sine table, depth is a power of two
	localparam int SINE_DEPTH = 256;
	localparam int SINE_AW    = $clog2(SINE_DEPTH);
	localparam int SINE_W     = 17;
	localparam int K_W        = SINE_AW + 2;

	// pipeline shape
	localparam int REM_STAGES   = DATA_W;
	localparam int PHASE_STAGES = K_W;
	localparam int PROD_W       = AMP_W + SINE_W;
	localparam int DP_W         = DUTY_W + DATA_W;
	localparam int SUM_W        = DATA_W + 2;

	// waveform codes
	localparam logic [WAVE_W-1:0] WAVE_STEP   = 2'd0;
	localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd1;
	localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd2;

	// register map
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_WAVEFORM   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DUTY       = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ACTIVATION = 3'd5;

	// reset values
	localparam logic [WAVE_W-1:0]        RST_WAVEFORM   = WAVE_STEP;
	localparam logic [AMP_W-1:0]         RST_AMPLITUDE  = 31'd131072;
	localparam logic [DATA_W-1:0]        RST_PERIOD     = 32'd1000;
	localparam logic [DUTY_W-1:0]        RST_DUTY       = 17'd32768;
	localparam logic signed [DATA_W-1:0] RST_OFFSET     = 32'sd131072;
	localparam logic [DATA_W-1:0]        RST_ACTIVATION = 32'd1000;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [SINE_DEPTH-1:0][SINE_W-1:0] sine_tab_t;

	// control bits that travel with an item
	typedef struct packed {
		logic valid;
		logic step_hit;
		logic sq_high;
	} swg_ctl_t;

	// one table entry from a q2.30 taylor series, rounded to q1.16
	function automatic logic [SINE_W-1:0] quarter_sine(input int idx);
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] sum;
		x = (HALF_PI_Q30 * 64'(idx)) / 64'(SINE_DEPTH);
		term = x;
		sum = $signed(x);
		for (int n = 1; n <= 8; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			if ((n % 2) == 1) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		sum = (sum + 64'sd8192) >>> 14;
		if (sum > 64'sd65536) begin
			sum = 64'sd65536;
		end
		return sum[SINE_W-1:0];
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t tab;
		tab = '0;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			tab[i] = quarter_sine(i);
		end
		return tab;
	endfunction

	localparam sine_tab_t         SINE_TAB = build_sine_tab();
	localparam logic [SINE_W-1:0] SINE_TOP = quarter_sine(SINE_DEPTH);

endpackage

// ===== rtl/setpoint_waveform_generator_core.sv =====
`timescale 1ns / 1ps
// the pipeline has 46 register stages between an accepted item and its result
// (32 remainder stages, 10 phase quotient stages, 4 table, multiply, round and sum stages)
// throughput is one item per cycle while the skid is empty, set by the fully pipelined bit-per-stage dividers
// an output skid register holds one untaken result, the input stalls while it is full
// reset: arst_n clears all valid bits and the skid, registers return to their defaults

module setpoint_waveform_generator_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [31:0]                       time_ms,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [31:0]                level,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [swg_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import swg_pkg::*;

	logic [WAVE_W-1:0]        waveform_q;
	logic [AMP_W-1:0]         amplitude_q;
	logic [DATA_W-1:0]        period_q;
	logic [DUTY_W-1:0]        duty_q;
	logic signed [DATA_W-1:0] offset_q;
	logic [DATA_W-1:0]        activation_q;

	logic [REG_IDX_W-1:0]     reg_idx;
	logic                     wr_en;
	logic                     en;

	swg_ctl_t                 rem_ctl;
	logic [DATA_W-1:0]        rem_val;
	swg_ctl_t                 ph_ctl;
	logic [K_W-1:0]           ph_k;
	logic                     last_valid;
	logic signed [DATA_W-1:0] last_level;

	logic                     skid_valid_q;
	logic signed [DATA_W-1:0] skid_level_q;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q   <= RST_WAVEFORM;
			amplitude_q  <= RST_AMPLITUDE;
			period_q     <= RST_PERIOD;
			duty_q       <= RST_DUTY;
			offset_q     <= RST_OFFSET;
			activation_q <= RST_ACTIVATION;
		end else if (wr_en) begin
			case (reg_idx)
				REG_WAVEFORM:   waveform_q   <= pwdata[WAVE_W-1:0];
				REG_AMPLITUDE:  amplitude_q  <= pwdata[AMP_W-1:0];
				REG_PERIOD:     period_q     <= pwdata;
				REG_DUTY:       duty_q       <= pwdata[DUTY_W-1:0];
				REG_OFFSET:     offset_q     <= pwdata;
				REG_ACTIVATION: activation_q <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_WAVEFORM:   prdata = DATA_W'(waveform_q);
			REG_AMPLITUDE:  prdata = DATA_W'(amplitude_q);
			REG_PERIOD:     prdata = period_q;
			REG_DUTY:       prdata = DATA_W'(duty_q);
			REG_OFFSET:     prdata = offset_q;
			REG_ACTIVATION: prdata = activation_q;
			default:        prdata = '0;
		endcase
	end

	// the pipeline moves whenever the skid is empty
	assign en       = !skid_valid_q;
	assign in_ready = en;

	swg_rem_div u_rem (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.in_valid      (in_valid),
		.time_ms       (time_ms),
		.period_ms     (period_q),
		.activation_ms (activation_q),
		.ctl_out       (rem_ctl),
		.rem_out       (rem_val)
	);

	swg_phase_div u_phase (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_in    (rem_ctl),
		.rem_in    (rem_val),
		.period_ms (period_q),
		.duty      (duty_q),
		.ctl_out   (ph_ctl),
		.k_out     (ph_k)
	);

	swg_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_in    (ph_ctl),
		.k_in      (ph_k),
		.waveform  (waveform_q),
		.amplitude (amplitude_q),
		.period_ms (period_q),
		.offset    (offset_q),
		.valid_out (last_valid),
		.level_out (last_level)
	);

	// output skid: catches a result that is not taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (last_valid && !out_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_valid_q && last_valid && !out_ready) begin
			skid_level_q <= last_level;
		end
	end

	assign out_valid = skid_valid_q || last_valid;
	assign level     = skid_valid_q ? skid_level_q : last_level;

	// skid only fills from an untaken result
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(last_valid && !out_ready))
		else $error("skid filled without a stalled result");

	// a held skid item stays put until taken
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_ready |=> skid_valid_q && $stable(skid_level_q))
		else $error("skid item lost or changed while stalled");

	// a stalled pipeline keeps its last stage
	a_pipe_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(last_valid) && $stable(last_level))
		else $error("pipeline moved while stalled");

endmodule

// ===== rtl/swg_rem_div.sv =====
`timescale 1ns / 1ps

module swg_rem_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [31:0]                time_ms,
	input  logic [31:0]                period_ms,
	input  logic [31:0]                activation_ms,
	output swg_pkg::swg_ctl_t          ctl_out,
	output logic [31:0]                rem_out
);
	import swg_pkg::*;

	logic [DATA_W-1:0] rem_s [REM_STAGES];
	logic [DATA_W-1:0] dvd_s [REM_STAGES-1];
	swg_ctl_t          ctl_s [REM_STAGES];

	logic [DATA_W-1:0] rem_src [REM_STAGES];
	logic [DATA_W-1:0] dvd_src [REM_STAGES];
	swg_ctl_t          ctl_src [REM_STAGES];
	logic [DATA_W-1:0] rem_nxt [REM_STAGES];
	logic [DATA_W-1:0] dvd_nxt [REM_STAGES];

	// stage inputs: the first stage takes the new item
	always_comb begin
		rem_src[0] = '0;
		dvd_src[0] = time_ms;
		ctl_src[0] = '{valid: in_valid, step_hit: (time_ms >= activation_ms), sq_high: 1'b0};
		for (int i = 1; i < REM_STAGES; i++) begin
			rem_src[i] = rem_s[i-1];
			dvd_src[i] = dvd_s[i-1];
			ctl_src[i] = ctl_s[i-1];
		end
	end

	// one restoring step per stage, one dividend bit each
	always_comb begin
		logic [DATA_W:0] part;
		part = '0;
		for (int i = 0; i < REM_STAGES; i++) begin
			part = {rem_src[i], dvd_src[i][DATA_W-1]};
			if (part >= {1'b0, period_ms}) begin
				part = part - {1'b0, period_ms};
			end
			rem_nxt[i] = part[DATA_W-1:0];
			dvd_nxt[i] = {dvd_src[i][DATA_W-2:0], 1'b0};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REM_STAGES; i++) begin
				ctl_s[i] <= '0;
			end
		end else if (en) begin
			for (int i = 0; i < REM_STAGES; i++) begin
				ctl_s[i] <= ctl_src[i];
			end
		end
	end

	// data registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < REM_STAGES; i++) begin
				rem_s[i] <= rem_nxt[i];
			end
			for (int i = 0; i < REM_STAGES - 1; i++) begin
				dvd_s[i] <= dvd_nxt[i];
			end
		end
	end

	assign ctl_out = ctl_s[REM_STAGES-1];
	assign rem_out = rem_s[REM_STAGES-1];

endmodule

// ===== rtl/swg_phase_div.sv =====
`timescale 1ns / 1ps

module swg_phase_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  swg_pkg::swg_ctl_t            ctl_in,
	input  logic [31:0]                  rem_in,
	input  logic [31:0]                  period_ms,
	input  logic [16:0]                  duty,
	output swg_pkg::swg_ctl_t            ctl_out,
	output logic [swg_pkg::K_W-1:0]      k_out
);
	import swg_pkg::*;

	logic [DP_W-1:0]   dp_q;
	logic [DATA_W-1:0] rem_s [PHASE_STAGES-1];
	logic [K_W-1:0]    k_s   [PHASE_STAGES];
	swg_ctl_t          ctl_s [PHASE_STAGES];

	logic [DATA_W-1:0] rem_src [PHASE_STAGES];
	logic [K_W-1:0]    k_src   [PHASE_STAGES];
	swg_ctl_t          ctl_src [PHASE_STAGES];
	logic [DATA_W-1:0] rem_nxt [PHASE_STAGES];
	logic [K_W-1:0]    k_nxt   [PHASE_STAGES];

	// duty threshold scaled to the period, static between config writes
	always_ff @(posedge clk) begin
		dp_q <= DP_W'(duty) * DP_W'(period_ms);
	end

	// stage inputs, square decision made on entry
	always_comb begin
		rem_src[0] = rem_in;
		k_src[0]   = '0;
		ctl_src[0] = ctl_in;
		ctl_src[0].sq_high = (DP_W'({rem_in, {FRAC_W{1'b0}}}) < dp_q);
		for (int i = 1; i < PHASE_STAGES; i++) begin
			rem_src[i] = rem_s[i-1];
			k_src[i]   = k_s[i-1];
			ctl_src[i] = ctl_s[i-1];
		end
	end

	// one quotient bit of rem * 4 * depth / period per stage
	always_comb begin
		logic [DATA_W:0] part;
		logic            qb;
		part = '0;
		qb = 1'b0;
		for (int i = 0; i < PHASE_STAGES; i++) begin
			part = {rem_src[i], 1'b0};
			qb = (part >= {1'b0, period_ms});
			if (qb) begin
				part = part - {1'b0, period_ms};
			end
			rem_nxt[i] = part[DATA_W-1:0];
			k_nxt[i]   = {k_src[i][K_W-2:0], qb};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PHASE_STAGES; i++) begin
				ctl_s[i] <= '0;
			end
		end else if (en) begin
			for (int i = 0; i < PHASE_STAGES; i++) begin
				ctl_s[i] <= ctl_src[i];
			end
		end
	end

	// data registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < PHASE_STAGES; i++) begin
				k_s[i] <= k_nxt[i];
			end
			for (int i = 0; i < PHASE_STAGES - 1; i++) begin
				rem_s[i] <= rem_nxt[i];
			end
		end
	end

	assign ctl_out = ctl_s[PHASE_STAGES-1];
	assign k_out   = k_s[PHASE_STAGES-1];

endmodule

// ===== rtl/swg_level.sv =====
`timescale 1ns / 1ps

module swg_level (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  swg_pkg::swg_ctl_t         ctl_in,
	input  logic [swg_pkg::K_W-1:0]   k_in,
	input  logic [1:0]                waveform,
	input  logic [30:0]               amplitude,
	input  logic [31:0]               period_ms,
	input  logic signed [31:0]        offset,
	output logic                      valid_out,
	output logic signed [31:0]        level_out
);
	import swg_pkg::*;

	logic [SINE_AW:0]          idx;
	logic [SINE_W-1:0]         sine_val;

	logic [SINE_W-1:0]         sine_s1;
	logic                      neg_s1;
	swg_ctl_t                  ctl_s1;
	logic [PROD_W-1:0]         prod_s2;
	logic                      neg_s2;
	swg_ctl_t                  ctl_s2;
	logic signed [DATA_W:0]    sv_s3;
	swg_ctl_t                  ctl_s3;
	logic signed [DATA_W-1:0]  level_s4;
	logic                      valid_s4;

	logic [PROD_W-1:0]         rnd;
	logic [DATA_W-1:0]         mag;
	logic signed [SUM_W-1:0]   sum;
	logic signed [SUM_W-1:0]   off_x;
	logic signed [DATA_W-1:0]  sat;
	logic signed [DATA_W-1:0]  lvl_nxt;

	// quadrant folding into the quarter-wave table
	always_comb begin
		if (k_in[K_W-2]) begin
			idx = (SINE_AW + 1)'(SINE_DEPTH) - {1'b0, k_in[SINE_AW-1:0]};
		end else begin
			idx = {1'b0, k_in[SINE_AW-1:0]};
		end
		if (idx[SINE_AW]) begin
			sine_val = SINE_TOP;
		end else begin
			sine_val = SINE_TAB[idx[SINE_AW-1:0]];
		end
	end

	// magnitude rounded half up, sign from the lower half-wave
	always_comb begin
		rnd = prod_s2 + PROD_W'(32768);
		mag = rnd[FRAC_W +: DATA_W];
	end

	// mode select, offset and saturation
	always_comb begin
		off_x = SUM_W'(offset);
		sum = '0;
		case (waveform)
			WAVE_STEP: begin
				sum = ctl_s3.step_hit ? off_x : '0;
			end
			WAVE_SINE: begin
				if (period_ms == '0) begin
					sum = off_x;
				end else begin
					sum = SUM_W'(sv_s3) + off_x;
				end
			end
			WAVE_SQUARE: begin
				if (period_ms == '0 || !ctl_s3.sq_high) begin
					sum = off_x;
				end else begin
					sum = $signed({3'b000, amplitude}) + off_x;
				end
			end
			default: begin
				sum = '0;
			end
		endcase
		if (sum[SUM_W-1:DATA_W-1] == '0 || sum[SUM_W-1:DATA_W-1] == '1) begin
			sat = sum[DATA_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
		lvl_nxt = sat;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s2   <= '0;
			ctl_s3   <= '0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			ctl_s1   <= ctl_in;
			ctl_s2   <= ctl_s1;
			ctl_s3   <= ctl_s2;
			valid_s4 <= ctl_s3.valid;
		end
	end

	// data registers
	always_ff @(posedge clk) begin
		if (en) begin
			sine_s1  <= sine_val;
			neg_s1   <= k_in[K_W-1];
			prod_s2  <= PROD_W'(amplitude) * PROD_W'(sine_s1);
			neg_s2   <= neg_s1;
			sv_s3    <= neg_s2 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
			level_s4 <= lvl_nxt;
		end
	end

	assign valid_out = valid_s4;
	assign level_out = level_s4;

endmodule

// ===== tb/setpoint_waveform_generator_core_test.sv =====
`timescale 1ns / 1ps

module setpoint_waveform_generator_core_test;

	import swg_pkg::*;

	localparam int          PIPE_LATENCY = 46;
	localparam int          CYCLE_LIMIT  = 300000;
	localparam int          RANDOM_ITEMS = 1100;
	localparam logic [63:0] HALF_PI_Q2_30 = 64'd1686629713;

	// codes the package leaves out
	localparam logic [WAVE_W-1:0]    WAVE_UNDEFINED = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI   = 3'd7;

	typedef struct {
		logic [31:0]        stamp;
		logic signed [31:0] level;
	} level_sample_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// block ports
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic [31:0]              time_ms   = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [31:0]       level;
	logic                     psel      = 1'b0;
	logic                     penable   = 1'b0;
	logic                     pwrite    = 1'b0;
	logic [ADDR_W-1:0]        paddr     = '0;
	logic [31:0]              pwdata    = '0;
	logic [31:0]              prdata;
	logic                     pready;

	setpoint_waveform_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.time_ms   (time_ms),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.level     (level),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// shadow copy of the register file
	logic [WAVE_W-1:0]  cfg_wave       = RST_WAVEFORM;
	logic [AMP_W-1:0]   cfg_amp        = RST_AMPLITUDE;
	logic [31:0]        cfg_period     = RST_PERIOD;
	logic [DUTY_W-1:0]  cfg_duty       = RST_DUTY;
	logic signed [31:0] cfg_offset     = RST_OFFSET;
	logic [31:0]        cfg_activation = RST_ACTIVATION;

	logic [SINE_W-1:0] quarter_wave [0:SINE_DEPTH];

	level_sample_t pending_levels [$];
	level_sample_t oldest;

	int failures       = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 8;
	int take_stall_pct = 8;
	int hold_left      = 0;

	// one quarter-wave entry: q2.30 taylor series, rounded to q1.16
	function automatic logic [SINE_W-1:0] taylor_quarter(input int idx);
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] acc;
		x = (HALF_PI_Q2_30 * 64'(idx)) / 64'(SINE_DEPTH);
		term = x;
		acc = $signed(x);
		for (int n = 1; n <= 8; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 64'((2 * n) * (2 * n + 1));
			acc = (n % 2 == 1) ? acc - $signed(term) : acc + $signed(term);
		end
		if (acc < 0) begin
			acc = '0;
		end
		acc = (acc + 64'sd8192) >>> 14;
		if (acc > 64'sd65536) begin
			acc = 64'sd65536;
		end
		return acc[SINE_W-1:0];
	endfunction

	// expected setpoint for one time stamp under the current settings
	function automatic logic signed [31:0] predict_level(input logic [31:0] t);
		logic [63:0]        r;
		logic [63:0]        ph;
		logic [63:0]        k;
		logic [63:0]        j;
		logic [63:0]        s;
		logic [63:0]        mag;
		logic [1:0]         quad;
		logic signed [63:0] off;
		logic signed [63:0] lvl;
		off = cfg_offset;
		lvl = '0;
		case (cfg_wave)
			WAVE_STEP: begin
				lvl = (t >= cfg_activation) ? off : 64'sd0;
			end
			WAVE_SINE, WAVE_SQUARE: begin
				if (cfg_period == 0) begin
					lvl = off;
				end else begin
					r = {32'd0, t} % {32'd0, cfg_period};
					if (cfg_wave == WAVE_SINE) begin
						ph = (r << 32) / {32'd0, cfg_period};
						k = (ph * 64'(4 * SINE_DEPTH)) >> 32;
						quad = 2'(k / 64'(SINE_DEPTH));
						j = k % 64'(SINE_DEPTH);
						s = quad[0] ? 64'(quarter_wave[SINE_DEPTH - j]) : 64'(quarter_wave[j]);
						mag = ({33'd0, cfg_amp} * s + 64'd32768) >> 16;
						lvl = (quad[1] ? -$signed(mag) : $signed(mag)) + off;
					end else if ((r << 16) < (64'(cfg_duty) * 64'(cfg_period))) begin
						lvl = $signed({33'd0, cfg_amp}) + off;
					end else begin
						lvl = off;
					end
				end
			end
			default: begin
				lvl = '0;
			end
		endcase
		if (lvl > 64'sd2147483647) begin
			lvl = 64'sd2147483647;
		end else if (lvl < -64'sd2147483648) begin
			lvl = -64'sd2147483648;
		end
		return lvl[31:0];
	endfunction

	// apb write, shadow copy follows with the same width masks
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WAVEFORM:   cfg_wave       = value[WAVE_W-1:0];
			REG_AMPLITUDE:  cfg_amp        = value[AMP_W-1:0];
			REG_PERIOD:     cfg_period     = value;
			REG_DUTY:       cfg_duty       = value[DUTY_W-1:0];
			REG_OFFSET:     cfg_offset     = value;
			REG_ACTIVATION: cfg_activation = value;
			default: ;
		endcase
	endtask

	// stop offering items and let the pipeline empty
	task automatic settle_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_levels.size() != 0) begin
			@(negedge clk);
		end
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	// offer one time stamp and log its expected level on acceptance
	task automatic send_time(input logic [31:0] t);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		time_ms  <= t;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		pending_levels.push_back('{stamp: t, level: predict_level(t)});
	endtask

	// receiver: random stalls, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= take_stall_pct);
		end
	end

	// compare each result with the oldest expected level
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("unexpected level %0d with nothing pending", level);
				end
			end else begin
				oldest = pending_levels.pop_front();
				if (level !== oldest.level) begin
					failures++;
					if (failures <= 10) begin
						$display("level mismatch at time_ms %0d: expected %0d, got %0d",
							oldest.stamp, oldest.level, level);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL setpoint_waveform_generator_core");
			$finish;
		end
	end

	// step mode with the reset settings: activation 1000 ms, offset 2.0
	task automatic test_reset_defaults();
		send_time(32'd0);
		send_time(32'd999);
		send_time(32'd1000);
		send_time(32'hFFFF_FFFF);
	endtask

	// step mode at the edges of time, activation and offset
	task automatic test_step_extremes();
		settle_pipeline();
		write_reg(REG_OFFSET, 32'h8000_0000);
		write_reg(REG_ACTIVATION, 32'd0);
		send_time(32'd0);
		settle_pipeline();
		write_reg(REG_OFFSET, 32'h7FFF_FFFF);
		write_reg(REG_ACTIVATION, 32'hFFFF_FFFF);
		send_time(32'hFFFF_FFFE);
		send_time(32'hFFFF_FFFF);
	endtask

	// sine peaks with saturation, quadrant edges, zero and full-range period
	task automatic test_sine_corners();
		settle_pipeline();
		write_reg(REG_WAVEFORM, {30'd0, WAVE_SINE});
		write_reg(REG_AMPLITUDE, 32'h7FFF_FFFF);
		write_reg(REG_PERIOD, 32'd1024);
		send_time(32'd256);
		send_time(32'd0);
		settle_pipeline();
		write_reg(REG_OFFSET, 32'h8000_0000);
		send_time(32'd768);
		settle_pipeline();
		write_reg(REG_AMPLITUDE, 32'h0001_0000);
		write_reg(REG_OFFSET, 32'd0);
		send_time(32'd512);
		send_time(32'd1023);
		settle_pipeline();
		write_reg(REG_PERIOD, 32'd0);
		send_time(32'd5);
		settle_pipeline();
		write_reg(REG_PERIOD, 32'hFFFF_FFFF);
		send_time(32'hFFFF_FFFE);
	endtask

	// square duty extremes, duty above full scale, exact threshold, zero period
	task automatic test_square_corners();
		settle_pipeline();
		write_reg(REG_WAVEFORM, {30'd0, WAVE_SQUARE});
		write_reg(REG_AMPLITUDE, 32'h7FFF_FFFF);
		write_reg(REG_OFFSET, 32'd1);
		write_reg(REG_PERIOD, 32'd3);
		write_reg(REG_DUTY, 32'd65536);
		send_time(32'd2);
		settle_pipeline();
		write_reg(REG_DUTY, 32'd0);
		send_time(32'd0);
		settle_pipeline();
		write_reg(REG_DUTY, 32'h0001_FFFF);
		send_time(32'd2);
		settle_pipeline();
		write_reg(REG_DUTY, 32'd32768);
		write_reg(REG_PERIOD, 32'd2);
		send_time(32'd0);
		send_time(32'd1);
		settle_pipeline();
		write_reg(REG_PERIOD, 32'd0);
		send_time(32'd7);
	endtask

	// undefined waveform code, writes to unmapped addresses are dropped
	task automatic test_undefined_waveform();
		settle_pipeline();
		write_reg(REG_WAVEFORM, {30'h3FFF_FFFF, WAVE_UNDEFINED});
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		send_time(32'd0);
		send_time(32'hFFFF_FFFF);
	endtask

	// random register image, biased to the extremes, junk in unused bits
	task automatic load_random_settings();
		logic [31:0] raw;
		raw = $urandom();
		case ($urandom_range(9))
			0, 1:    raw[WAVE_W-1:0] = WAVE_STEP;
			2, 3, 4: raw[WAVE_W-1:0] = WAVE_SINE;
			9:       raw[WAVE_W-1:0] = WAVE_UNDEFINED;
			default: raw[WAVE_W-1:0] = WAVE_SQUARE;
		endcase
		write_reg(REG_WAVEFORM, raw);
		raw = $urandom();
		case ($urandom_range(4))
			0: raw[AMP_W-1:0] = '0;
			1: raw[AMP_W-1:0] = '1;
			2: raw[AMP_W-1:0] = AMP_W'($urandom_range(32'h0004_0000));
			default: ;
		endcase
		write_reg(REG_AMPLITUDE, raw);
		case ($urandom_range(6))
			0: raw = 32'd0;
			1: raw = 32'd1;
			2: raw = 32'hFFFF_FFFF;
			3: raw = $urandom_range(2, 64);
			4: raw = $urandom_range(65, 5000);
			default: raw = $urandom();
		endcase
		write_reg(REG_PERIOD, raw);
		raw = $urandom();
		case ($urandom_range(5))
			0: raw[DUTY_W-1:0] = '0;
			1: raw[DUTY_W-1:0] = 17'd65536;
			2: raw[DUTY_W-1:0] = '1;
			3: raw[DUTY_W-1:0] = DUTY_W'($urandom_range(65536));
			default: ;
		endcase
		write_reg(REG_DUTY, raw);
		case ($urandom_range(5))
			0: raw = 32'h8000_0000;
			1: raw = 32'h7FFF_FFFF;
			2: raw = 32'd0;
			3: raw = $urandom_range(32'h0008_0000) - 32'h0004_0000;
			default: raw = $urandom();
		endcase
		write_reg(REG_OFFSET, raw);
		case ($urandom_range(4))
			0: raw = 32'd0;
			1: raw = 32'hFFFF_FFFF;
			2: raw = $urandom_range(5000);
			default: raw = $urandom();
		endcase
		write_reg(REG_ACTIVATION, raw);
		if ($urandom_range(3) == 0) begin
			write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
		end
	endtask

	// time stamps spread over the range and packed near the interesting edges
	function automatic logic [31:0] pick_time();
		logic [31:0] t;
		case ($urandom_range(3))
			0: t = $urandom();
			1: t = cfg_activation + $urandom_range(16) - 32'd8;
			2: t = cfg_period * $urandom_range(20) + $urandom_range(16) - 32'd8;
			default: t = $urandom_range(4000);
		endcase
		return t;
	endfunction

	// random settings, a batch of random time stamps under each
	task automatic test_random_sweeps();
		int sent;
		int batch;
		int phase;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			settle_pipeline();
			load_random_settings();
			// one batch runs with no idling on either side
			send_idle_pct  = (phase == 3) ? 0 : 8;
			take_stall_pct = (phase == 3) ? 0 : 8;
			batch = $urandom_range(40, 110);
			repeat (batch) begin
				send_time(pick_time());
			end
			sent += batch;
			phase++;
		end
		send_idle_pct  = 8;
		take_stall_pct = 8;
	endtask

	// receiver holds off long enough that the pipeline and skid fill up
	task automatic test_output_backpressure();
		settle_pipeline();
		write_reg(REG_WAVEFORM, {30'd0, WAVE_SINE});
		write_reg(REG_AMPLITUDE, 32'h0003_0000);
		write_reg(REG_OFFSET, 32'hFFFF_0000);
		write_reg(REG_PERIOD, 32'd97);
		send_idle_pct = 0;
		hold_left = 300;
		repeat (150) begin
			send_time(pick_time());
		end
		send_idle_pct = 8;
	endtask

	initial begin
		for (int i = 0; i <= SINE_DEPTH; i++) begin
			quarter_wave[i] = taylor_quarter(i);
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_step_extremes();
		test_sine_corners();
		test_square_corners();
		test_undefined_waveform();
		test_random_sweeps();
		test_output_backpressure();
		settle_pipeline();

		if (failures == 0) begin
			$display("PASS setpoint_waveform_generator_core");
		end else begin
			$display("FAIL setpoint_waveform_generator_core");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/swg_pkg.sv
rtl/swg_rem_div.sv
rtl/swg_phase_div.sv
rtl/swg_level.sv
rtl/setpoint_waveform_generator_core.sv
tb/setpoint_waveform_generator_core_test.sv
